>>> sv/modbus_rtu_frame_receiver_assert.svh
// Assertion macros for the Modbus RTU frame receiver.
`ifndef MODBUS_RTU_FRAME_RECEIVER_ASSERT_SVH
`define MODBUS_RTU_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define MBRTU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define MBRTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mbrtu_pkg.sv
// Package: types and constants of the Modbus RTU frame receiver.
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [7:0]  LONG_FUNC_MIN    = 8'd7;
  localparam logic [8:0]  FIXED_PAYLOAD    = 9'd4;
  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_FUNC   = 3'd1,
    PH_FIXED  = 3'd2,
    PH_COUNT  = 3'd3,
    PH_VALUE  = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_ADDR    = 3'd0,
    ROLE_FUNC    = 3'd1,
    ROLE_PAYLOAD = 3'd2,
    ROLE_CRC_LO  = 3'd3,
    ROLE_CRC_HI  = 3'd4
  } role_t;

  typedef struct packed {
    logic [7:0] byte_value;
    role_t      byte_role;
    logic [8:0] payload_index;
    logic       frame_end;
    logic       crc_ok;
    logic       address_match;
    logic [8:0] payload_length;
  } res_t;

endpackage

>>> sv/mbrtu_if.sv
// Interfaces: received-byte channel and per-byte result channel.
`timescale 1ns / 1ps

interface mbrtu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbrtu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] byte_role;
  logic [8:0] payload_index;
  logic       frame_end;
  logic       crc_ok;
  logic       address_match;
  logic [8:0] payload_length;

  modport source (output valid, output byte_value, output byte_role, output payload_index,
                  output frame_end, output crc_ok, output address_match,
                  output payload_length, input ready);
  modport sink (input valid, input byte_value, input byte_role, input payload_index,
                input frame_end, input crc_ok, input address_match,
                input payload_length, output ready);
endinterface

>>> sv/modbus_rtu_frame_receiver.sv
// Modbus RTU request receiver: one result per received byte, CRC and address check at frame end.
// Takes one byte per clock while the result side keeps taking items; a byte accepted into the input
// register moves on into the result register once that is free, and its result is presented there (input
// register, then result register). Throughput is one byte per cycle as long as the result side keeps taking
// items; the path between the registers is the byte-wide CRC-16 update, eight unrolled
// shift/xor steps, plus the frame state decode. The result register lets a new byte enter
// while a finished result still waits. slave_address resets to 1 and is sampled when a
// frame's address byte is processed.
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver
  import mbrtu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              slave_address_we,
  input  logic [7:0]        slave_address,
  mbrtu_rx_if.sink          rx,
  mbrtu_res_if.source       res
);

  logic [7:0] slave_addr_reg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  res_t       out_data;
  res_t       fsm_result;
  logic       advance;

  // item moves from the input register into the result register
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr_reg <= SLAVE_ADDR_RESET;
    end else if (slave_address_we) begin
      slave_addr_reg <= slave_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  mbrtu_frame_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data          (in_byte),
    .slave_address (slave_addr_reg),
    .result        (fsm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= fsm_result;
    end
  end

  assign res.valid          = out_valid;
  assign res.byte_value     = out_data.byte_value;
  assign res.byte_role      = out_data.byte_role;
  assign res.payload_index  = out_data.payload_index;
  assign res.frame_end      = out_data.frame_end;
  assign res.crc_ok         = out_data.crc_ok;
  assign res.address_match  = out_data.address_match;
  assign res.payload_length = out_data.payload_length;

endmodule

>>> sv/mbrtu_crc_update.sv
// CRC-16/MODBUS update over one byte, unrolled bit by bit.
`timescale 1ns / 1ps

module mbrtu_crc_update
  import mbrtu_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> sv/mbrtu_frame_fsm.sv
// Frame state machine: byte roles, payload counting, running CRC, end-of-frame checks.
`timescale 1ns / 1ps

module mbrtu_frame_fsm
  import mbrtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  input  logic [7:0] slave_address,
  output res_t       result
);

  phase_t      phase, phase_next;
  logic [8:0]  payload_count, payload_count_next;
  logic [8:0]  expected_length, expected_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [7:0]  function_code, function_code_next;
  logic        address_hit, address_hit_next;

  logic [15:0] crc_seed;
  logic [15:0] crc_fed;
  logic [8:0]  count_inc;

  assign crc_seed  = (phase == PH_FUNC || phase == PH_FIXED || phase == PH_COUNT ||
                      phase == PH_VALUE) ? running_crc : CRC_INIT;
  assign count_inc = payload_count + 9'd1;

  mbrtu_crc_update u_crc (
    .crc_in  (crc_seed),
    .data    (data),
    .crc_out (crc_fed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ADDR;
      payload_count   <= '0;
      expected_length <= '0;
      running_crc     <= CRC_INIT;
      crc_low_byte    <= '0;
      function_code   <= '0;
      address_hit     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      payload_count   <= payload_count_next;
      expected_length <= expected_length_next;
      running_crc     <= running_crc_next;
      crc_low_byte    <= crc_low_byte_next;
      function_code   <= function_code_next;
      address_hit     <= address_hit_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    payload_count_next   = payload_count;
    expected_length_next = expected_length;
    running_crc_next     = running_crc;
    crc_low_byte_next    = crc_low_byte;
    function_code_next   = function_code;
    address_hit_next     = address_hit;

    result                = '0;
    result.byte_value     = data;
    result.byte_role      = ROLE_ADDR;

    case (phase)
      PH_FUNC: begin
        result.byte_role   = ROLE_FUNC;
        function_code_next = data;
        payload_count_next = '0;
        running_crc_next   = crc_fed;
        phase_next         = PH_FIXED;
      end
      PH_FIXED: begin
        result.byte_role     = ROLE_PAYLOAD;
        result.payload_index = payload_count;
        running_crc_next     = crc_fed;
        payload_count_next   = count_inc;
        if (count_inc >= FIXED_PAYLOAD) begin
          if (function_code < LONG_FUNC_MIN) begin
            expected_length_next = count_inc;
            phase_next           = PH_CRC_LO;
          end else begin
            phase_next = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        result.byte_role     = ROLE_PAYLOAD;
        result.payload_index = payload_count;
        running_crc_next     = crc_fed;
        payload_count_next   = count_inc;
        expected_length_next = count_inc + {1'b0, data};
        // zero byte count goes straight to the CRC
        phase_next           = (data == 8'd0) ? PH_CRC_LO : PH_VALUE;
      end
      PH_VALUE: begin
        result.byte_role     = ROLE_PAYLOAD;
        result.payload_index = payload_count;
        running_crc_next     = crc_fed;
        payload_count_next   = count_inc;
        if (count_inc >= expected_length) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        result.byte_role  = ROLE_CRC_LO;
        crc_low_byte_next = data;
        phase_next        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        result.byte_role      = ROLE_CRC_HI;
        result.frame_end      = 1'b1;
        result.crc_ok         = ({data, crc_low_byte} == running_crc);
        result.address_match  = address_hit;
        result.payload_length = payload_count;
        running_crc_next      = CRC_INIT;
        phase_next            = PH_ADDR;
      end
      default: begin
        // address byte; also recovers from the unused phase code
        result.byte_role     = ROLE_ADDR;
        address_hit_next     = (data == slave_address);
        running_crc_next     = crc_fed;
        payload_count_next   = '0;
        expected_length_next = '0;
        phase_next           = PH_FUNC;
      end
    endcase
  end

endmodule

>>> sv/mbrtu_checker.sv
// Port-level checks for the Modbus RTU frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "modbus_rtu_frame_receiver_assert.svh"

module mbrtu_port_checker
  import mbrtu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_value,
  input logic [2:0] byte_role,
  input logic [8:0] payload_index,
  input logic       frame_end,
  input logic       crc_ok,
  input logic       address_match,
  input logic [8:0] payload_length
);

  `MBRTU_ASSERT_NOW(a_end_on_crc_hi, clk, rst, out_valid && frame_end, byte_role == ROLE_CRC_HI, "frame end on a byte that is not the CRC high byte")
  `MBRTU_ASSERT_NOW(a_flags_only_at_end, clk, rst, out_valid && byte_role != ROLE_CRC_HI, !frame_end && !crc_ok && !address_match && payload_length == 9'd0, "end-of-frame fields set before frame end")
  `MBRTU_ASSERT_NOW(a_index_only_payload, clk, rst, out_valid && byte_role != ROLE_PAYLOAD, payload_index == 9'd0, "payload index on a non-payload byte")
  `MBRTU_ASSERT_NOW(a_min_length, clk, rst, out_valid && frame_end, payload_length >= FIXED_PAYLOAD, "frame shorter than the fixed payload")
  `MBRTU_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_value) && $stable(byte_role), "result changed while stalled")

endmodule

bind modbus_rtu_frame_receiver mbrtu_port_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .byte_value     (res.byte_value),
  .byte_role      (res.byte_role),
  .payload_index  (res.payload_index),
  .frame_end      (res.frame_end),
  .crc_ok         (res.crc_ok),
  .address_match  (res.address_match),
  .payload_length (res.payload_length)
);
